FILE: design/lscs_pkg.sv
package lscs_pkg;

    localparam int MAX_SHELLS = 16;
    localparam int COS_W      = 16;
    localparam int LEN_W      = 22;
    localparam int DENS_W     = 10;
    localparam int ADDR_LAND  = 0;
    // wide enough for r^2 * 2^(2F) at F = 16 (radius < 2^13)
    localparam int SQ_W       = 60;
    localparam int ROOT_W     = SQ_W / 2;

    typedef logic [SQ_W-1:0]   t_sq;
    typedef logic [ROOT_W-1:0] t_root;

    // Shell outer radii in km, innermost first; unused entries are zero
    function automatic logic [12:0] shell_radius(input logic [3:0] k);
        case (k)
            4'd0:    shell_radius = 13'd1221;
            4'd1:    shell_radius = 13'd3480;
            4'd2:    shell_radius = 13'd5701;
            4'd3:    shell_radius = 13'd5971;
            4'd4:    shell_radius = 13'd6363;
            4'd5:    shell_radius = 13'd6371;
            default: shell_radius = 13'd0;
        endcase
    endfunction

    function automatic logic [DENS_W-1:0] shell_ne(input logic [3:0] k);
        case (k)
            4'd0:    shell_ne = 10'd615;
            4'd1:    shell_ne = 10'd536;
            4'd2:    shell_ne = 10'd247;
            4'd3:    shell_ne = 10'd193;
            4'd4:    shell_ne = 10'd150;
            4'd5:    shell_ne = 10'd150;
            default: shell_ne = 10'd0;
        endcase
    endfunction

    function automatic logic [DENS_W-1:0] shell_nn(input logic [3:0] k);
        case (k)
            4'd0:    shell_nn = 10'd650;
            4'd1:    shell_nn = 10'd565;
            4'd2:    shell_nn = 10'd250;
            4'd3:    shell_nn = 10'd195;
            4'd4:    shell_nn = 10'd150;
            4'd5:    shell_nn = 10'd150;
            default: shell_nn = 10'd0;
        endcase
    endfunction

    localparam logic [DENS_W-1:0] OCEAN_NE = 10'd50;
    localparam logic [DENS_W-1:0] OCEAN_NN = 10'd40;

    // Datapath commands from the controller
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,  // capture input, start s2 = 2^30 - c^2
        OP_CCD   = 3'd2,  // chord-centre distance squared
        OP_ROOT  = 3'd3,  // start root for shell cmd.idx
        OP_STEP  = 3'd4,  // one root iteration
        OP_STORE = 3'd5,  // store rounded root into half[idx]
        OP_SEG   = 3'd6   // build segment list entry for shell idx
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] idx;
    } t_cmd;

    typedef struct packed {
        logic       neg;      // captured cosine is negative
        logic       root_done;
        logic [4:0] nseg;     // segments kept so far
    } t_sts;

endpackage

FILE: design/lscs_datapath.sv
module lscs_datapath
    import lscs_pkg::*;
#(
    parameter int NUM_SHELLS       = 6,
    parameter int LENGTH_FRAC_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic signed [COS_W-1:0] i_cos,
    input  logic [4:0]              i_rd_idx,
    input  logic                    i_land,
    output t_sts                    o_sts,
    output logic [LEN_W-1:0]        o_len,
    output logic [DENS_W-1:0]       o_ne,
    output logic [DENS_W-1:0]       o_nn
);

    localparam int F2 = 2 * LENGTH_FRAC_BITS;

    logic signed [COS_W-1:0] r_c;
    logic [31:0]             r_s2;
    t_sq                     r_ccd;
    t_sq                     r_rem;
    t_sq                     r_q;
    t_sq                     r_bit;
    logic                    r_busy;
    t_root                   r_half [MAX_SHELLS];
    t_sq                     r_seg_len [MAX_SHELLS];
    logic [3:0]              r_seg_sh [MAX_SHELLS];
    logic [4:0]              r_nseg;

    logic [61:0] w_prod;
    t_sq         w_rk2;
    t_sq         w_qb;
    logic [3:0]  w_i;
    logic [12:0] w_r;
    logic [3:0]  w_sh;
    logic [4:0]  w_n;
    logic [4:0]  w_tot;
    logic [4:0]  w_src;
    logic [3:0]  w_wr;
    logic [3:0]  w_wr_prev;

    assign w_i  = i_cmd.idx;
    assign w_r  = shell_radius(w_i);
    assign w_rk2 = t_sq'({34'd0, w_r} * {34'd0, w_r}) << F2;
    assign w_prod = 62'(shell_radius(4'(NUM_SHELLS - 1)))
                  * 62'(shell_radius(4'(NUM_SHELLS - 1))) * 62'(r_s2);
    assign w_qb = r_q + r_bit;

    // segment list write slots: next free entry and the last kept one
    assign w_wr      = r_nseg[3:0];
    assign w_wr_prev = 4'(r_nseg - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_nseg <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_c    <= i_cos;
                    r_nseg <= '0;
                    r_s2   <= 32'h4000_0000 - 32'($signed(i_cos) * $signed(i_cos));
                end
                OP_CCD: begin
                    if (F2 >= 30)
                        r_ccd <= t_sq'(w_prod) << (F2 - 30);
                    else
                        r_ccd <= t_sq'((64'(w_prod) + (64'd1 << (29 - F2))) >> (30 - F2));
                end
                OP_ROOT: begin
                    r_q    <= '0;
                    r_bit  <= t_sq'(1) << (SQ_W - 2);
                    r_rem  <= (r_ccd <= w_rk2) ? w_rk2 - r_ccd : '0;
                    r_busy <= 1'b1;
                end
                OP_STEP: begin
                    if (r_bit != '0) begin
                        if (r_rem >= w_qb) begin
                            r_rem <= r_rem - w_qb;
                            r_q   <= (r_q >> 1) + r_bit;
                        end else begin
                            r_q <= r_q >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_busy <= 1'b0;
                    end
                end
                OP_STORE: begin
                    r_half[w_i] <= t_root'((r_rem > r_q) ? r_q + 1'b1 : r_q);
                end
                OP_SEG: begin
                    // shells above core: positive differences; idx 0 finishes the core
                    if (w_i != 4'd0) begin
                        if (r_half[w_i] > r_half[w_i - 1'b1]) begin
                            r_seg_len[w_wr] <= t_sq'(r_half[w_i] - r_half[w_i - 1'b1]);
                            r_seg_sh[w_wr]  <= w_i;
                            r_nseg          <= r_nseg + 1'b1;
                        end
                    end else if (r_half[0] != '0) begin
                        r_seg_len[w_wr] <= t_sq'(r_half[0]) << 1;
                        r_seg_sh[w_wr]  <= 4'd0;
                        r_nseg          <= r_nseg + 1'b1;
                    end else if (r_nseg != '0) begin
                        r_seg_len[w_wr_prev] <= r_seg_len[w_wr_prev] << 1;
                    end
                end
                default: ;
            endcase
        end
    end

    // mirrored readout: index j >= n maps to total-1-j
    assign w_n   = r_nseg;
    assign w_tot = 5'((w_n << 1) - 1'b1);
    assign w_src = (i_rd_idx < w_n) ? i_rd_idx : 5'(w_tot - 1'b1 - i_rd_idx);
    assign w_sh  = r_seg_sh[w_src[3:0]];

    always_comb begin
        o_len = (r_seg_len[w_src[3:0]] > t_sq'(22'h3FFFFF))
              ? 22'h3FFFFF : LEN_W'(r_seg_len[w_src[3:0]]);
        if (w_sh == 4'(NUM_SHELLS - 1) && !i_land) begin
            o_ne = OCEAN_NE;
            o_nn = OCEAN_NN;
        end else begin
            o_ne = shell_ne(w_sh);
            o_nn = shell_nn(w_sh);
        end
    end

    assign o_sts.neg       = r_c[COS_W-1];
    assign o_sts.root_done = !r_busy;
    assign o_sts.nseg      = r_nseg;

endmodule

FILE: design/lscs_ctrl.sv
module lscs_ctrl
    import lscs_pkg::*;
#(
    parameter int NUM_SHELLS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic       o_zero,
    output logic       o_last,
    output logic [4:0] o_rd_idx,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHK   = 9'b000000010,
        S_CCD   = 9'b000000100,
        S_ROOT  = 9'b000001000,
        S_STEP  = 9'b000010000,
        S_STORE = 9'b000100000,
        S_SEG   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_ZERO  = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_k, n_k;
    logic [4:0] r_j, n_j;
    logic [4:0] w_tot;

    assign w_tot = 5'((i_sts.nseg << 1) - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_j         = r_j;
        o_cmd.op    = OP_NONE;
        o_cmd.idx   = r_k;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_zero      = 1'b0;
        o_last      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: n_state = i_sts.neg ? S_CCD : S_ZERO;
            S_CCD: begin
                o_cmd.op = OP_CCD;
                n_k      = '0;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOT;
                n_state  = S_STEP;
            end
            S_STEP: begin
                o_cmd.op = OP_STEP;
                if (i_sts.root_done) n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.op = OP_STORE;
                if (r_k == 4'(NUM_SHELLS - 1)) begin
                    n_state = S_SEG;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_ROOT;
                end
            end
            S_SEG: begin
                // walk shells outermost to core
                o_cmd.op = OP_SEG;
                if (r_k == '0) begin
                    n_j     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.nseg == '0) begin
                    n_state = S_ZERO;
                end else begin
                    o_out_valid = 1'b1;
                    o_last      = (r_j == w_tot - 1'b1);
                    if (i_out_ready) begin
                        n_j = r_j + 1'b1;
                        if (o_last) n_state = S_IDLE;
                    end
                end
            end
            S_ZERO: begin
                o_out_valid = 1'b1;
                o_zero      = 1'b1;
                o_last      = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rd_idx = r_j;

endmodule

FILE: design/layered_sphere_chord_segments.sv
// Each shell takes a start step, 30 bit-pair root iterations and a finish, and a store; then
// one segment-build step per shell runs before the first result is offered.
// A new input is taken only after the last result of the previous one has left; downward
// items skip the shell work. Results leave one per cycle while tready is high.
// Reset: synchronous active-low i_rst_n; controller idles, land_mode returns to 1.
module layered_sphere_chord_segments
    import lscs_pkg::*;
#(
    parameter int NUM_SHELLS       = 6,
    parameter int LENGTH_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] zenith cosine, signed Q1.15
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [21:0] segment_length, [31:22] electron_density,
                                        // [41:32] neutron_density, zero fill
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             r_land;
    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [4:0]       w_rd;
    logic             w_zero;
    logic [LEN_W-1:0] w_len;
    logic [DENS_W-1:0] w_ne, w_nn;

    // config register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_land <= 1'b1;
        end else if (psel && penable && pwrite && paddr == 2'(ADDR_LAND * 4)) begin
            r_land <= pwdata[0];
        end
    end
    assign prdata = (paddr == 2'(ADDR_LAND * 4)) ? {31'd0, r_land} : 32'd0;

    lscs_ctrl #(.NUM_SHELLS(NUM_SHELLS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_zero      (w_zero),
        .o_last      (m_axis_tlast),
        .o_rd_idx    (w_rd),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lscs_datapath #(
        .NUM_SHELLS       (NUM_SHELLS),
        .LENGTH_FRAC_BITS (LENGTH_FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_cos    (s_axis_tdata),
        .i_rd_idx (w_rd),
        .i_land   (r_land),
        .o_sts    (w_sts),
        .o_len    (w_len),
        .o_ne     (w_ne),
        .o_nn     (w_nn)
    );

    assign m_axis_tdata = w_zero ? 48'd0 : {6'd0, w_nn, w_ne, w_len};

endmodule

FILE: design/lscs_checker.sv
module lscs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // input is never taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input accepted during output");

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // after the last transfer the block is ready for input
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not idle after last");

    // padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:42] == 6'd0) else $error("pad nonzero");

endmodule

bind layered_sphere_chord_segments lscs_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: test/tb_layered_sphere_chord_segments.sv
module tb_layered_sphere_chord_segments;
    import lscs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SH      = 6;
    localparam int FRAC      = 8;
    localparam int WATCHDOG  = 20000;
    localparam int SETTLE    = 300;
    localparam int MAX_ERR   = 100;

    typedef struct packed {
        logic [LEN_W-1:0]  seg_len;
        logic [DENS_W-1:0] ne;
        logic [DENS_W-1:0] nn;
        logic              last;
    } t_seg;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    layered_sphere_chord_segments #(.NUM_SHELLS(N_SH), .LENGTH_FRAC_BITS(FRAC)) uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_seg  seg_queue[$];
    logic  land_sel;
    int    n_err = 0;
    int    n_in = 0;
    int    n_out = 0;
    int    idle_cnt = 0;
    int    src_idle_pct = 0;
    int    snk_idle_pct = 0;
    bit    snk_hold = 1'b0;

    task automatic report(input string what, input t_seg got, input t_seg exp_seg);
        n_err++;
        $display("mismatch %s at result %0d: got len=%0d ne=%0d nn=%0d last=%0b, %s%0d %s%0d %s%0d %s%0b",
                 what, n_out, got.seg_len, got.ne, got.nn, got.last,
                 "want len=", exp_seg.seg_len, "ne=", exp_seg.ne, "nn=", exp_seg.nn,
                 "last=", exp_seg.last);
    endtask

    // bit-pair square root, rounded to nearest
    function automatic longint unsigned isqrt_round(input longint unsigned v);
        longint unsigned q, b, r;
        q = 0;
        b = 64'd1 << 62;
        r = v;
        while (b > r) b >>= 2;
        while (b != 0) begin
            if (r >= q + b) begin
                r -= q + b;
                q = (q >> 1) + b;
            end else begin
                q >>= 1;
            end
            b >>= 2;
        end
        if (r > q) q++;
        return q;
    endfunction

    function automatic t_seg mk_seg(input longint unsigned len, input int sh, input bit last);
        t_seg s;
        s.seg_len = (len > 64'h3FFFFF) ? 22'h3FFFFF : len[LEN_W-1:0];
        if (sh == N_SH - 1 && !land_sel) begin
            s.ne = OCEAN_NE;
            s.nn = OCEAN_NN;
        end else begin
            s.ne = shell_ne(4'(sh));
            s.nn = shell_nn(4'(sh));
        end
        s.last = last;
        return s;
    endfunction

    // expected chord segments for one zenith cosine
    task automatic predict_chords(input logic signed [15:0] cz);
        longint unsigned half[16];
        longint unsigned lens[32];
        int              shells[32];
        longint unsigned s2, rr, ccd2, rk, rk2;
        longint          cc;
        int              n, tot;
        n = 0;
        if (cz >= 0) begin
            seg_queue.push_back('{0, 0, 0, 1'b1});
            return;
        end
        cc = longint'(cz) * longint'(cz);
        s2 = (64'd1 << 30) - cc;
        rr = 64'(shell_radius(4'(N_SH - 1))) * 64'(shell_radius(4'(N_SH - 1)));
        if (2 * FRAC >= 30) ccd2 = (rr * s2) << (2 * FRAC - 30);
        else ccd2 = (rr * s2 + (64'd1 << (29 - 2 * FRAC))) >> (30 - 2 * FRAC);
        for (int k = 0; k < N_SH; k++) begin
            rk = shell_radius(4'(k));
            rk2 = (rk * rk) << (2 * FRAC);
            half[k] = (ccd2 <= rk2) ? isqrt_round(rk2 - ccd2) : 0;
        end
        for (int k = N_SH - 1; k >= 1; k--) begin
            if (half[k] > half[k-1]) begin
                lens[n] = half[k] - half[k-1];
                shells[n] = k;
                n++;
            end
        end
        if (half[0] == 0) begin
            if (n == 0) begin
                seg_queue.push_back('{0, 0, 0, 1'b1});
                return;
            end
            lens[n-1] *= 2;
        end else begin
            lens[n] = 2 * half[0];
            shells[n] = 0;
            n++;
        end
        tot = 2 * n - 1;
        for (int j = n; j < tot; j++) begin
            lens[j] = lens[tot-1-j];
            shells[j] = shells[tot-1-j];
        end
        for (int j = 0; j < tot; j++) seg_queue.push_back(mk_seg(lens[j], shells[j], j == tot - 1));
    endtask

    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == 2'(ADDR_LAND)) land_sel = data[0];
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // one input transfer; the sender idles at the current rate
    task automatic send_cos(input logic [15:0] cz);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = cz;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_chords(cz);
        n_in++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (seg_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // receiver ready, random idling plus an optional long hold
    always @(negedge i_clk) begin
        m_axis_tready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        t_seg got, want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || psel)
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt > WATCHDOG) begin
                $display("FAIL layered_sphere_chord_segments");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.seg_len = m_axis_tdata[21:0];
                got.ne = m_axis_tdata[31:22];
                got.nn = m_axis_tdata[41:32];
                got.last = m_axis_tlast;
                if (seg_queue.size() == 0) begin
                    report("unexpected", got, '0);
                end else begin
                    want = seg_queue.pop_front();
                    if (got.seg_len != want.seg_len) report("segment_length", got, want);
                    if (got.ne != want.ne) report("electron_density", got, want);
                    if (got.nn != want.nn) report("neutron_density", got, want);
                    if (got.last != want.last) report("last_segment", got, want);
                end
                n_out++;
            end
            // too many mismatches end the run
            if (n_err > MAX_ERR) begin
                $display("FAIL layered_sphere_chord_segments");
                $finish;
            end
        end
    end

    // directed stimulus: extremes, downward, vertical, grazing, shell edges
    logic [15:0] dir_cos[] = '{
        16'h0000, 16'h7FFF, 16'h0001, 16'h8000, 16'hFFFF, 16'h8001,
        16'hC000, 16'hA57E, 16'hE000, 16'hF800, 16'hFF00, 16'hFFF0,
        16'h9000, 16'hB000, 16'hD000, 16'h5555, 16'hAAAA, 16'hF000
    };

    initial begin
        land_sel = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset state: a downward path gives one empty flagged segment
        send_cos(16'h1234);
        drain();

        foreach (dir_cos[i]) send_cos(dir_cos[i]);
        drain();
        apb_write(2'(ADDR_LAND), 32'h0);
        foreach (dir_cos[i]) send_cos(dir_cos[i]);
        drain();
        apb_write(2'(ADDR_LAND), 32'hFFFF_FFFF);

        // long receiver hold while inputs keep coming
        snk_hold = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                snk_hold = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_cos(16'h8000 | 16'($urandom_range(16'h7FFF)));
        join
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 61 : 0;
            snk_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 14 : 0;
            for (int i = 0; i < 145; i++) begin
                // random cosines, with extra downward and grazing ones
                case ($urandom_range(9))
                    0: send_cos(16'($urandom_range(16'h7FFF)));
                    1: send_cos(16'hFFFF - 16'($urandom_range(16'h00FF)));
                    default: send_cos(16'($urandom));
                endcase
            end
            drain();
            apb_write(2'(ADDR_LAND), {31'($urandom_range(32'h7FFF_FFFF)), ph[0]});
        end

        $display("covered %0d paths, %0d segments, both crust settings, idle mixes and a long hold",
                 n_in, n_out);
        if (n_err == 0 && seg_queue.size() == 0) begin
            $display("PASS layered_sphere_chord_segments");
        end else begin
            $display("FAIL layered_sphere_chord_segments");
        end
        $finish;
    end

endmodule

FILE: layered_sphere_chord_segments.f
design/lscs_pkg.sv
design/lscs_datapath.sv
design/lscs_ctrl.sv
design/layered_sphere_chord_segments.sv
design/lscs_checker.sv
test/tb_layered_sphere_chord_segments.sv
